@@ hdl/multi_button_history_debouncer_top_assert.svh @@
// Assertion macros shared by the debouncer RTL.
// Included by the top level, the module that carries concurrent checks; no other dependencies.
`ifndef MULTI_BUTTON_HISTORY_DEBOUNCER_TOP_ASSERT_SVH
`define MULTI_BUTTON_HISTORY_DEBOUNCER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MBHD_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("debouncer assertion failed");
`define MBHD_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("debouncer assertion failed");
`else
`define MBHD_ASSERT_RST(label, clk, rst, prop)
`define MBHD_ASSERT_CLK(label, clk, prop)
`endif
`endif

@@ hdl/mbhd_pkg.sv @@
// Types, register codes and reset values for the multi-button debouncer.
// Used by the update unit and the top level; no dependencies.
package mbhd_pkg;

  localparam int BUTTONS_DEF = 16;
  localparam int MAX_BUTTONS = 16;
  localparam int HIST_W      = 8;
  localparam int CNT_W       = 32;
  localparam int MASK_W      = 16;
  localparam int BTN_W       = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_PATTERN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_PATTERN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_RELEASES  = 3'd4;

  localparam logic [MASK_W-1:0] RST_ENABLE_MASK     = 16'h0000;
  localparam logic [HIST_W-1:0] RST_HISTORY_MASK    = 8'hC7;
  localparam logic [HIST_W-1:0] RST_PRESS_PATTERN   = 8'h07;
  localparam logic [HIST_W-1:0] RST_RELEASE_PATTERN = 8'hC0;

  localparam logic [HIST_W-1:0] HIST_ALL_ONES = 8'hFF;

  typedef struct packed {
    logic [MASK_W-1:0] enable_mask;
    logic [HIST_W-1:0] history_mask;
    logic [HIST_W-1:0] press_pattern;
    logic [HIST_W-1:0] release_pattern;
    logic              count_releases;
  } cfg_t;

  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic              wait_rel;
    logic              flag;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  pstamp;
    logic [CNT_W-1:0]  rstamp;
  } btn_state_t;

  typedef struct packed {
    logic enable;
    logic pin;
    logic clear;
  } btn_ctl_t;

  typedef struct packed {
    btn_state_t st;
    logic       pressed;
    logic       released;
  } upd_t;

endpackage

@@ hdl/mbhd_update_unit.sv @@
// Shared per-button update: history shift, pattern match, count and stamps.
// Depends on mbhd_pkg; used once by the top level for every button in turn.
module mbhd_update_unit
  import mbhd_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [CNT_W-1:0] tick,
  input  btn_ctl_t         ctl,
  input  btn_state_t       st_in,
  output upd_t             upd
);

  logic [HIST_W-1:0] shifted;
  logic              match_press;
  logic              match_release;

  assign shifted       = {st_in.hist[HIST_W-2:0], ctl.pin};
  assign match_press   = (shifted & cfg.history_mask) == cfg.press_pattern;
  assign match_release = (shifted & cfg.history_mask) == cfg.release_pattern;

  always_comb begin
    upd.st       = st_in;
    upd.pressed  = 1'b0;
    upd.released = 1'b0;
    if (ctl.enable) begin
      upd.st.hist = shifted;
      if (!st_in.wait_rel) begin
        if (match_press) begin
          upd.pressed     = 1'b1;
          upd.st.hist     = HIST_ALL_ONES;
          upd.st.count    = st_in.count + CNT_W'(1);
          upd.st.wait_rel = 1'b1;
          upd.st.pstamp   = tick;
          if (!cfg.count_releases) begin
            upd.st.flag = 1'b1;
          end
        end
      end else if (match_release) begin
        upd.released    = 1'b1;
        upd.st.hist     = '0;
        upd.st.wait_rel = 1'b0;
        upd.st.rstamp   = tick;
        if (cfg.count_releases) begin
          upd.st.count = st_in.count + CNT_W'(1);
        end
      end
    end
    // Clearing comes after the update, so it also wins over a new event.
    if (ctl.clear) begin
      upd.st.count  = '0;
      upd.st.pstamp = '0;
      upd.st.rstamp = '0;
    end
  end

endmodule

@@ hdl/multi_button_history_debouncer_top.sv @@
// Multi-button history debouncer: takes one beat of sampled pin levels per
// tick and returns one result beat per button, from index 0 upward. A single
// update unit serves the buttons one after another, so a tick beat is followed
// by BUTTONS result beats at one per cycle while out_ready stays high, and the
// next tick beat is taken once the last button is updated, so no tick beat is
// taken while the sequencer still serves buttons. Configuration writes are
// meant for idle periods between ticks.
// Depends on mbhd_pkg, mbhd_update_unit and the assertion header.
`include "multi_button_history_debouncer_top_assert.svh"

module multi_button_history_debouncer_top
  import mbhd_pkg::*;
#(
  parameter int BUTTONS = BUTTONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MASK_W-1:0]    pin_levels,
  input  logic [MASK_W-1:0]    clear_requests,
  input  logic [MASK_W-1:0]    flag_ack,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BTN_W-1:0]     button_index,
  output logic [CNT_W-1:0]     event_count,
  output logic [CNT_W-1:0]     press_stamp,
  output logic [CNT_W-1:0]     release_stamp,
  output logic                 pressed_event,
  output logic                 released_event,
  output logic                 awaiting_release,
  output logic                 request_flag,
  output logic                 is_last
);

  localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTONS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t state, state_next;
  cfg_t       cfg;

  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   tick;
  logic [BUTTONS-1:0] pins_q;
  logic [BUTTONS-1:0] clears_q;
  logic [BUTTONS-1:0] request_flags;

  logic [HIST_W-1:0] hist_arr   [BUTTONS];
  logic              wait_arr   [BUTTONS];
  logic [CNT_W-1:0]  count_arr  [BUTTONS];
  logic [CNT_W-1:0]  pstamp_arr [BUTTONS];
  logic [CNT_W-1:0]  rstamp_arr [BUTTONS];

  logic       accept;
  logic       adv;
  logic       last_btn;
  btn_ctl_t   ctl;
  btn_state_t st_cur;
  upd_t       upd;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign adv      = (state == ST_RUN) && (!out_valid || out_ready);
  assign last_btn = (idx == LAST_IDX);

  assign ctl.enable = cfg.enable_mask[BTN_W'(idx)];
  assign ctl.pin    = pins_q[idx];
  assign ctl.clear  = clears_q[idx];

  assign st_cur.hist     = hist_arr[idx];
  assign st_cur.wait_rel = wait_arr[idx];
  assign st_cur.flag     = request_flags[idx];
  assign st_cur.count    = count_arr[idx];
  assign st_cur.pstamp   = pstamp_arr[idx];
  assign st_cur.rstamp   = rstamp_arr[idx];

  mbhd_update_unit u_update (
    .cfg   (cfg),
    .tick  (tick),
    .ctl   (ctl),
    .st_in (st_cur),
    .upd   (upd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && last_btn) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mask     <= RST_ENABLE_MASK;
      cfg.history_mask    <= RST_HISTORY_MASK;
      cfg.press_pattern   <= RST_PRESS_PATTERN;
      cfg.release_pattern <= RST_RELEASE_PATTERN;
      cfg.count_releases  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE_MASK:     cfg.enable_mask     <= cfg_data;
        REG_HISTORY_MASK:    cfg.history_mask    <= cfg_data[HIST_W-1:0];
        REG_PRESS_PATTERN:   cfg.press_pattern   <= cfg_data[HIST_W-1:0];
        REG_RELEASE_PATTERN: cfg.release_pattern <= cfg_data[HIST_W-1:0];
        REG_COUNT_RELEASES:  cfg.count_releases  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      tick          <= '0;
      request_flags <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        hist_arr[i]   <= '0;
        wait_arr[i]   <= 1'b0;
        count_arr[i]  <= '0;
        pstamp_arr[i] <= '0;
        rstamp_arr[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        tick          <= tick + CNT_W'(1);
        idx           <= '0;
        request_flags <= request_flags & ~flag_ack[BUTTONS-1:0];
      end
      if (adv) begin
        hist_arr[idx]      <= upd.st.hist;
        wait_arr[idx]      <= upd.st.wait_rel;
        count_arr[idx]     <= upd.st.count;
        pstamp_arr[idx]    <= upd.st.pstamp;
        rstamp_arr[idx]    <= upd.st.rstamp;
        request_flags[idx] <= upd.st.flag;
        if (!last_btn) begin
          idx <= idx + IDX_W'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Beat payload registers; pins and clears load on accept, the result fields only together with out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      pins_q   <= pin_levels[BUTTONS-1:0];
      clears_q <= clear_requests[BUTTONS-1:0];
    end
    if (adv) begin
      button_index     <= BTN_W'(idx);
      event_count      <= upd.st.count;
      press_stamp      <= upd.st.pstamp;
      release_stamp    <= upd.st.rstamp;
      pressed_event    <= upd.pressed;
      released_event   <= upd.released;
      awaiting_release <= upd.st.wait_rel;
      request_flag     <= upd.st.flag;
      is_last          <= last_btn;
    end
  end

  `MBHD_ASSERT_RST(a_start_at_zero, clk, rst, accept |=> (state == ST_RUN) && (idx == '0))
  `MBHD_ASSERT_RST(a_done_idle, clk, rst, (adv && last_btn) |=> (state == ST_IDLE) && is_last)
  `MBHD_ASSERT_RST(a_one_event, clk, rst, out_valid |-> !(pressed_event && released_event))
  `MBHD_ASSERT_RST(a_press_waits, clk, rst, (out_valid && pressed_event) |-> awaiting_release)
  `MBHD_ASSERT_RST(a_release_idle, clk, rst, (out_valid && released_event) |-> !awaiting_release)

endmodule
